@@ rtl/sghc_pkg.sv @@
`default_nettype none
package sghc_pkg;

  // Quantization of each color channel into the skin table address.
  localparam int QUANT_BITS  = 5;
  localparam int CHAN_W      = 8;
  localparam int TABLE_BITS  = 3 * QUANT_BITS;
  localparam int TABLE_DEPTH = 1 << TABLE_BITS;

  // Hue arithmetic.
  localparam int HUE_SCALE   = 46;
  localparam int SEXTANTS    = 6;
  localparam int OFS_RED     = 4;
  localparam int OFS_BLUE    = 2;
  localparam int N_W         = 11;  // holds SEXTANTS * 255
  localparam int DIVIDEND_W  = 17;  // holds SEXTANTS * 255 * HUE_SCALE
  localparam int QUOT_W      = 9;   // quotient never exceeds SEXTANTS * HUE_SCALE

  localparam logic [CHAN_W-1:0] THRESHOLD_RESET = CHAN_W'(125);

  // Input word modes.
  localparam logic MODE_CONVERT = 1'b0;
  localparam logic MODE_WRITE   = 1'b1;

  // Word that travels down the divider cells. The upper dividend bits start
  // in rem; the lower ones shift out of bits while quotient bits shift in.
  typedef struct packed {
    logic              skin;
    logic              zero;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] rem;
    logic [QUOT_W-1:0] bits;
  } div_word_t;

  function automatic logic [TABLE_BITS-1:0] lut_addr(
    input logic [CHAN_W-1:0] b,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] r
  );
    lut_addr = {b[CHAN_W-1 -: QUANT_BITS], g[CHAN_W-1 -: QUANT_BITS],
                r[CHAN_W-1 -: QUANT_BITS]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/sghc_skin_lut.sv @@
`default_nettype none
module sghc_skin_lut (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [sghc_pkg::TABLE_BITS-1:0] wr_addr,
  input  wire logic [sghc_pkg::CHAN_W-1:0]     wr_data,
  input  wire logic                            rd_en,
  input  wire logic [sghc_pkg::TABLE_BITS-1:0] rd_addr,
  output logic      [sghc_pkg::CHAN_W-1:0]     rd_data_r
);

  logic [sghc_pkg::CHAN_W-1:0] mem [sghc_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read data holds while the following stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sghc_hue_prep.sv @@
`default_nettype none
module sghc_hue_prep (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [sghc_pkg::CHAN_W-1:0] blue_i,
  input  wire logic [sghc_pkg::CHAN_W-1:0] green_i,
  input  wire logic [sghc_pkg::CHAN_W-1:0] red_i,
  input  wire logic [sghc_pkg::CHAN_W-1:0] lut_byte_i,
  input  wire logic [sghc_pkg::CHAN_W-1:0] threshold_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output sghc_pkg::div_word_t              word_o
);

  localparam int SW = sghc_pkg::N_W + 1;

  logic                          a_valid_r, a_valid_nxt;
  logic                          a_skin_r;
  logic                          a_zero_r;
  logic [sghc_pkg::CHAN_W-1:0]   a_delta_r;
  logic [sghc_pkg::N_W-1:0]      a_n_r;
  logic                          b_valid_r, b_valid_nxt;
  sghc_pkg::div_word_t           b_word_r;
  logic                          a_ready;
  logic                          b_ready;

  logic [sghc_pkg::CHAN_W-1:0]     mx, mn, dl;
  logic signed [SW-1:0]            sd, sr, sg, sb, num;
  logic [sghc_pkg::DIVIDEND_W-1:0] dvd;

  assign b_ready = !b_valid_r || ready_i;
  assign a_ready = !a_valid_r || b_ready;
  assign ready_o = a_ready;
  assign valid_o = b_valid_r;
  assign word_o  = b_word_r;

  // Max, min and the sextant numerator; ties go to red, then green.
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dl = mx - mn;
    sd = $signed(SW'(dl));
    sr = $signed(SW'(red_i));
    sg = $signed(SW'(green_i));
    sb = $signed(SW'(blue_i));
    if (red_i == mx) begin
      num = sd * SW'(sghc_pkg::OFS_RED) + sg - sb;
    end else if (green_i == mx) begin
      num = sb - sr;
    end else begin
      num = sd * SW'(sghc_pkg::OFS_BLUE) + sr - sg;
    end
    if (num < 0) begin
      num = num + sd * SW'(sghc_pkg::SEXTANTS);
    end
  end

  assign dvd = sghc_pkg::DIVIDEND_W'(a_n_r) * sghc_pkg::DIVIDEND_W'(sghc_pkg::HUE_SCALE);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_ready) a_valid_nxt = valid_i;
    b_valid_nxt = b_valid_r;
    if (b_ready) b_valid_nxt = a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && valid_i) begin
      a_skin_r  <= lut_byte_i >= threshold_i;
      a_zero_r  <= (lut_byte_i < threshold_i) || (dl == '0);
      a_delta_r <= dl;
      a_n_r     <= num[sghc_pkg::N_W-1:0];
    end
    if (b_ready && a_valid_r) begin
      b_word_r.skin  <= a_skin_r;
      b_word_r.zero  <= a_zero_r;
      b_word_r.delta <= a_delta_r;
      b_word_r.rem   <= dvd[sghc_pkg::DIVIDEND_W-1 -: sghc_pkg::CHAN_W];
      b_word_r.bits  <= dvd[sghc_pkg::QUOT_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sghc_div_cell.sv @@
`default_nettype none
module sghc_div_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire sghc_pkg::div_word_t word_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output sghc_pkg::div_word_t      word_o
);

  logic                          valid_r, valid_nxt;
  sghc_pkg::div_word_t           word_r, word_nxt;
  logic [sghc_pkg::CHAN_W:0]     trial;
  logic [sghc_pkg::CHAN_W:0]     diff;
  logic                          qbit;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign word_o  = word_r;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    trial    = {word_i.rem, word_i.bits[sghc_pkg::QUOT_W-1]};
    diff     = trial - {1'b0, word_i.delta};
    qbit     = trial >= {1'b0, word_i.delta};
    word_nxt = word_i;
    word_nxt.rem  = qbit ? diff[sghc_pkg::CHAN_W-1:0] : trial[sghc_pkg::CHAN_W-1:0];
    word_nxt.bits = {word_i.bits[sghc_pkg::QUOT_W-2:0], qbit};
    valid_nxt = valid_r;
    if (ready_o) valid_nxt = valid_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/skin_gated_hue_convert.sv @@
`default_nettype none
// A convert word passes through 13 registers on its way to the result: table read, two hue
// stages, nine divider cells, output. Write words update the table and leave no result.
// Throughput: one word per cycle while the output is not stalled by out_ready.
// A stage holds its word only when its successor cannot take one, so input words keep
// coming in while a result waits on out_ready, until all 13 stages are full.
// Reset (synchronous, rst_n low) empties the pipeline and sets the threshold to 125.
module skin_gated_hue_convert (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_red,
  input  wire logic [14:0] in_table_index,
  input  wire logic [7:0]  in_table_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_hue_value,
  output logic             out_is_skin,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_skin_threshold
);

  localparam int NC = sghc_pkg::QUOT_W;

  logic                        cfg_acc;
  logic [sghc_pkg::CHAN_W-1:0] threshold_r;
  logic                        in_acc;
  logic                        conv_acc;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [sghc_pkg::CHAN_W-1:0] s1_blue_r, s1_green_r, s1_red_r;
  logic [sghc_pkg::CHAN_W-1:0] lut_byte;
  logic                        s1_ready;

  logic                        cell_vld [NC+1];
  logic                        cell_rdy [NC+1];
  sghc_pkg::div_word_t         cell_word [NC+1];

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_hue_r;
  logic                        out_skin_r;
  logic                        out_stage_ready;
  sghc_pkg::div_word_t         last_word;

  // The threshold register is always ready to take a configuration word.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= sghc_pkg::THRESHOLD_RESET;
    end else if (cfg_acc) begin
      threshold_r <= cfg_skin_threshold;
    end
  end

  // Stage 1: table access. Write words go straight into the table; convert
  // words read the entry their quantized color selects.
  assign in_ready = s1_ready;
  assign in_acc   = in_valid && in_ready;
  assign conv_acc = in_acc && (in_mode == sghc_pkg::MODE_CONVERT);

  sghc_skin_lut u_lut (
    .clk       (clk),
    .wr_en     (in_acc && (in_mode == sghc_pkg::MODE_WRITE)),
    .wr_addr   (in_table_index[sghc_pkg::TABLE_BITS-1:0]),
    .wr_data   (in_table_value),
    .rd_en     (conv_acc),
    .rd_addr   (sghc_pkg::lut_addr(in_blue, in_green, in_red)),
    .rd_data_r (lut_byte)
  );

  logic prep_ready;
  assign s1_ready = !s1_valid_r || prep_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) s1_valid_nxt = conv_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_acc) begin
      s1_blue_r  <= in_blue;
      s1_green_r <= in_green;
      s1_red_r   <= in_red;
    end
  end

  // Stages 2 and 3: skin decision, sextant numerator and the scaled dividend.
  sghc_hue_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (s1_valid_r),
    .ready_o     (prep_ready),
    .blue_i      (s1_blue_r),
    .green_i     (s1_green_r),
    .red_i       (s1_red_r),
    .lut_byte_i  (lut_byte),
    .threshold_i (threshold_r),
    .valid_o     (cell_vld[0]),
    .ready_i     (cell_rdy[0]),
    .word_o      (cell_word[0])
  );

  // The divider is a row of identical cells, one quotient bit per cell, most
  // significant bit first. Each cell passes its word on to the next one.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    sghc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cell_vld[k]),
      .ready_o (cell_rdy[k]),
      .word_i  (cell_word[k]),
      .valid_o (cell_vld[k+1]),
      .ready_i (cell_rdy[k+1]),
      .word_o  (cell_word[k+1])
    );
  end

  // Output register: saturate the quotient and zero the hue for grey or
  // non-skin pixels.
  assign last_word       = cell_word[NC];
  assign out_stage_ready = !out_valid_r || out_ready;
  assign cell_rdy[NC]    = out_stage_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_stage_ready) out_valid_nxt = cell_vld[NC];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_stage_ready && cell_vld[NC]) begin
      out_skin_r <= last_word.skin;
      if (last_word.zero) begin
        out_hue_r <= '0;
      end else if (last_word.bits[sghc_pkg::QUOT_W-1]) begin
        out_hue_r <= '1;
      end else begin
        out_hue_r <= last_word.bits[7:0];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hue_value = out_hue_r;
  assign out_is_skin   = out_skin_r;

endmodule
`default_nettype wire

@@ rtl/sghc_checker.sv @@
`default_nettype none
module sghc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_hue_value,
  input wire logic       out_is_skin
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hue_value) && $stable(out_is_skin))
    else $error("result word changed while stalled");

  // Non-skin pixels never carry a hue.
  a_nonskin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_skin |-> out_hue_value == 8'd0)
    else $error("non-skin pixel with nonzero hue");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind skin_gated_hue_convert sghc_checker u_sghc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hue_value (out_hue_value),
  .out_is_skin   (out_is_skin)
);
`default_nettype wire
